// ===== src/asgr_pkg.sv =====
// Shared types and constants for the ANSI SGR text cell writer.
package asgr_pkg;

    localparam logic [7:0] MAX_COLUMNS = 8'd128;
    localparam logic [6:0] MAX_ROWS    = 7'd64;

    localparam logic [7:0] RESET_COLUMNS = 8'd80;
    localparam logic [6:0] RESET_ROWS    = 7'd25;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [15:0] SYM_ESC     = 16'h001B;
    localparam logic [15:0] SYM_LF      = 16'h000A;
    localparam logic [15:0] SYM_CR      = 16'h000D;
    localparam logic [15:0] SYM_BRACKET = 16'h005B;
    localparam logic [15:0] SYM_M       = 16'h006D;
    localparam logic [15:0] SYM_SEMI    = 16'h003B;
    localparam logic [15:0] SYM_ZERO    = 16'h0030;
    localparam logic [15:0] SYM_NINE    = 16'h0039;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [4:0] FG_DEFAULT = 5'd9;

    localparam logic [6:0] SGR_RESET   = 7'd0;
    localparam logic [6:0] SGR_BOLD    = 7'd1;
    localparam logic [6:0] SGR_FG_LO   = 7'd30;
    localparam logic [6:0] SGR_FG_HI   = 7'd39;
    localparam logic [6:0] SGR_BG_LO   = 7'd40;
    localparam logic [6:0] SGR_BG_HI   = 7'd47;
    localparam logic [6:0] SGR_BG_ZMAX = 7'd49;
    localparam logic [4:0] BOLD_OFFSET = 5'd10;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESCAPE,
        MODE_BRACKET
    } t_mode;

    typedef enum logic {
        KIND_CELL  = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic       wrapped;
    } t_req;

endpackage

// ===== src/asgr_front.sv =====
// Front end: configuration, SGR parser, colour and cursor state, request build.
module asgr_front
    import asgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_accept,
    input  logic [15:0] i_symbol,
    output logic        o_push,
    output t_req        o_req,
    output logic [7:0]  o_cols
);

    logic [7:0] r_cfg_cols;
    logic [6:0] r_cfg_rows;
    t_mode      r_mode, n_mode;
    logic [6:0] r_num, n_num;
    logic [4:0] r_fg, n_fg;
    logic [2:0] r_bg, n_bg;
    logic       r_bold, n_bold;
    logic [5:0] r_row, n_row;
    logic [6:0] r_col, n_col;
    logic       r_wrap, n_wrap;

    logic [7:0] cols_eff;
    logic [6:0] rows_eff;
    logic [6:0] col_sat;
    logic [5:0] row_sat;
    logic [6:0] row_inc;
    logic [5:0] row_adv;
    logic       wrap_adv;
    logic [7:0] col_inc;
    logic       is_digit;
    logic [6:0] digit;
    logic       num_accept;

    always_comb begin
        if (r_cfg_cols == 8'd0)             cols_eff = 8'd1;
        else if (r_cfg_cols > MAX_COLUMNS)  cols_eff = MAX_COLUMNS;
        else                                cols_eff = r_cfg_cols;
        if (r_cfg_rows == 7'd0)             rows_eff = 7'd1;
        else if (r_cfg_rows > MAX_ROWS)     rows_eff = MAX_ROWS;
        else                                rows_eff = r_cfg_rows;
    end

    // clamp a cursor left outside a shrunken grid
    always_comb begin
        col_sat  = ({1'b0, r_col} >= cols_eff) ? 7'(cols_eff - 8'd1) : r_col;
        row_sat  = ({1'b0, r_row} >= rows_eff) ? 6'(rows_eff - 7'd1) : r_row;
        row_inc  = {1'b0, row_sat} + 7'd1;
        wrap_adv = (row_inc >= rows_eff);
        row_adv  = wrap_adv ? 6'd0 : row_inc[5:0];
        col_inc  = {1'b0, col_sat} + 8'd1;
        is_digit = (i_symbol >= SYM_ZERO) && (i_symbol <= SYM_NINE);
        digit    = 7'(i_symbol - SYM_ZERO);
        num_accept = (r_num <= 7'd9);
    end

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        if (i_accept) begin
            unique case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = (i_symbol == SYM_BRACKET) ? MODE_BRACKET : MODE_PLAIN;
                end
                MODE_BRACKET: begin
                    if (i_symbol == SYM_M)
                        n_mode = MODE_PLAIN;
                    else if (i_symbol == SYM_SEMI)
                        n_mode = MODE_BRACKET;
                    else if (is_digit && (r_num == 7'd0 || num_accept))
                        n_mode = MODE_BRACKET;
                    else
                        n_mode = MODE_PLAIN;
                end
                default: begin
                    n_mode = (i_symbol == SYM_ESC) ? MODE_ESCAPE : MODE_PLAIN;
                end
            endcase
        end
    end

    // datapath and request for each mode
    always_comb begin
        n_num  = r_num;
        n_fg   = r_fg;
        n_bg   = r_bg;
        n_bold = r_bold;
        n_row  = r_row;
        n_col  = r_col;
        n_wrap = r_wrap;
        o_push = 1'b0;
        o_req  = '0;
        if (i_accept) begin
            n_row = row_sat;
            n_col = col_sat;
            unique case (r_mode)
                MODE_ESCAPE: begin
                    n_num = 7'd0;
                end
                MODE_BRACKET: begin
                    if (i_symbol == SYM_M || i_symbol == SYM_SEMI) begin
                        n_num = 7'd0;
                        if (r_num == SGR_RESET) begin
                            n_fg   = FG_DEFAULT;
                            n_bg   = 3'd0;
                            n_bold = 1'b0;
                        end else if (r_num == SGR_BOLD) begin
                            n_bold = 1'b1;
                        end
                        if (r_num >= SGR_FG_LO && r_num <= SGR_FG_HI) begin
                            n_fg = 5'(r_num - SGR_FG_LO) + (r_bold ? BOLD_OFFSET : 5'd0);
                        end else if (r_num >= SGR_BG_LO && r_num <= SGR_BG_ZMAX) begin
                            n_bg = (r_num > SGR_BG_HI) ? 3'd0 : 3'(r_num - SGR_BG_LO);
                        end
                    end else if (is_digit) begin
                        if (r_num == 7'd0)
                            n_num = digit;
                        else if (num_accept)
                            n_num = 7'(r_num * 7'd10) + digit;
                    end
                end
                default: begin
                    if (i_symbol == SYM_ESC) begin
                        n_num = 7'd0;
                    end else if (i_symbol == SYM_CR) begin
                        n_col = 7'd0;
                    end else if (i_symbol == SYM_LF) begin
                        n_col  = 7'd0;
                        n_row  = row_adv;
                        n_wrap = r_wrap | wrap_adv;
                        o_push = 1'b1;
                        o_req.kind      = KIND_CLEAR;
                        o_req.row       = row_adv;
                        o_req.col       = 7'd0;
                        o_req.char_code = CHAR_SPACE;
                        o_req.attribute = 8'd0;
                        o_req.wrapped   = r_wrap | wrap_adv;
                    end else begin
                        o_push = 1'b1;
                        o_req.kind      = KIND_CELL;
                        o_req.row       = row_sat;
                        o_req.col       = col_sat;
                        o_req.char_code = i_symbol[7:0];
                        o_req.attribute = {r_bg, r_fg};
                        o_req.wrapped   = r_wrap;
                        // advance, moving to the next row at row end
                        if (col_inc >= cols_eff) begin
                            n_col  = 7'd0;
                            n_row  = row_adv;
                            n_wrap = r_wrap | wrap_adv;
                            o_req.wrapped = r_wrap | wrap_adv;
                        end else begin
                            n_col = col_inc[6:0];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= RESET_COLUMNS;
            r_cfg_rows <= RESET_ROWS;
            r_mode     <= MODE_PLAIN;
            r_num      <= 7'd0;
            r_fg       <= FG_DEFAULT;
            r_bg       <= 3'd0;
            r_bold     <= 1'b0;
            r_row      <= 6'd0;
            r_col      <= 7'd0;
            r_wrap     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_COLUMNS) r_cfg_cols <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_ROWS)    r_cfg_rows <= i_cfg_data[6:0];
            r_mode <= n_mode;
            r_num  <= n_num;
            r_fg   <= n_fg;
            r_bg   <= n_bg;
            r_bold <= n_bold;
            r_row  <= n_row;
            r_col  <= n_col;
            r_wrap <= n_wrap;
        end
    end

    assign o_cols = cols_eff;

endmodule

// ===== src/asgr_queue.sv =====
// Short request queue between the parser and the cell write stage.
module asgr_queue
    import asgr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output t_req o_req,
    output logic o_empty,
    output logic o_full
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (i_pop && !i_push)
                r_count <= r_count - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("request popped from an empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== src/asgr_back.sv =====
// Back end: cell address computation and the output register.
module asgr_back
    import asgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_empty,
    input  logic [7:0]  i_cols,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_write_kind,
    output logic [12:0] o_cell_index,
    output logic [7:0]  o_char_code,
    output logic [7:0]  o_attribute,
    output logic        o_wrapped
);

    logic        r_valid;
    logic [13:0] cell_sum;

    assign o_pop    = !i_empty && (!r_valid || i_ready);
    assign cell_sum = (14'(i_req.row) * 14'(i_cols)) + 14'(i_req.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_write_kind <= i_req.kind;
            o_cell_index <= cell_sum[12:0];
            o_char_code  <= i_req.char_code;
            o_attribute  <= i_req.attribute;
            o_wrapped    <= i_req.wrapped;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== src/ansi_sgr_text_cell_writer_unit.sv =====
// Top level of the ANSI SGR text cell writer.
//
// Input channel: i_valid / o_ready carry one 16-bit symbol per request.
// Output channel: o_valid / i_ready carry one cell write or row clear.
// Configuration: i_cfg_we with i_cfg_index selects column_count (0) or
// row_count (1); i_cfg_data is taken at the clock edge, no handshake.
//
// The parser and cursor logic take one symbol per cycle while o_ready is
// high and push a write request into a two-entry queue. The back stage
// computes the cell index (one small multiply) and registers the result,
// so a symbol that makes a write passes through the queue and then the
// output register before it shows on the outputs. Throughput is one
// symbol per cycle as long as the receiver takes results. Escape
// sequences and carriage returns produce no output.
// When the receiver stalls, the output register holds and the queue fills;
// o_ready falls once the queue is full. Reset clears the parser, colour,
// cursor and queue, and restores the 80 x 25 grid size.
module ansi_sgr_text_cell_writer_unit
    import asgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_symbol,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_kind,
    output logic [12:0] o_cell_index,
    output logic [7:0]  o_char_code,
    output logic [7:0]  o_attribute,
    output logic        o_wrapped
);

    logic       accept;
    logic       push;
    t_req       front_req;
    t_req       queue_req;
    logic [7:0] cols;
    logic       pop;
    logic       q_empty;
    logic       q_full;

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    asgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_symbol    (i_symbol),
        .o_push      (push),
        .o_req       (front_req),
        .o_cols      (cols)
    );

    asgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_req   (queue_req),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    asgr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (queue_req),
        .i_empty      (q_empty),
        .i_cols       (cols),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_write_kind (o_write_kind),
        .o_cell_index (o_cell_index),
        .o_char_code  (o_char_code),
        .o_attribute  (o_attribute),
        .o_wrapped    (o_wrapped)
    );

endmodule
